// ===== rtl/core/fblq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblq_pkg
// Shared constants and types for the finite buffer link queue.
// ----------------------------------------------------------------------------
package fblq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS   = 48;

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int LIMIT_W     = 7;
    localparam int BYTE_TIME_W = 24;
    localparam int SIZE_W      = 16;
    localparam int SERVICE_W   = 32;
    localparam int COUNT_W     = 32;
    localparam int SUM_W       = 64;
    localparam int FIELD7_W    = 7;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_LIMIT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTE_TIME    = 8'd1;

    localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = 7'd50;
    localparam logic [BYTE_TIME_W-1:0] BYTE_TIME_RESET = 24'd341333;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;

endpackage

// ===== rtl/core/fblq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fblq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/finite_buffer_link_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// finite_buffer_link_queue_unit
// Tail-drop link buffer: retires departed packets, admits or drops arrivals.
// ----------------------------------------------------------------------------
// Each packet word goes through a retirement phase, in which R packets are
// retired from the buffer, and an admission phase before the next packet can
// be accepted. The departure times sit in one RAM with a registered read, and
// retirement pops one head entry per cycle against the arrival time. Admission
// computes the departure, delay and counter updates once the output register
// is free. A new packet is accepted only once the previous result has been
// loaded into the output register, which may still be waiting to be taken.
module finite_buffer_link_queue_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [fblq_pkg::TIME_BITS-1:0]       arrival_time,
    input  logic [fblq_pkg::SIZE_W-1:0]          packet_size,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 accepted,
    output logic [fblq_pkg::TIME_BITS-1:0]       departure_time,
    output logic [fblq_pkg::TIME_BITS-1:0]       queue_delay,
    output logic [fblq_pkg::FIELD7_W-1:0]        retired_now,
    output logic [fblq_pkg::FIELD7_W-1:0]        occupancy,
    output logic [fblq_pkg::COUNT_W-1:0]         lost_total,
    output logic [fblq_pkg::COUNT_W-1:0]         done_total,
    output logic [fblq_pkg::SUM_W-1:0]           delay_sum,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fblq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fblq_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_POP   = 2'd1;
    localparam logic [1:0] ST_ADMIT = 2'd2;

    localparam int TS_W  = fblq_pkg::CNT_W + 1;
    localparam int PROD_W = fblq_pkg::SIZE_W + fblq_pkg::BYTE_TIME_W;

    logic [1:0]                           state_reg, state_next;
    fblq_pkg::time_t                      arr_reg, arr_next;
    logic [fblq_pkg::SIZE_W-1:0]          size_reg, size_next;
    logic [fblq_pkg::SERVICE_W-1:0]       service_reg;
    fblq_pkg::addr_t                      head_reg, head_next;
    fblq_pkg::cnt_t                       held_reg, held_next;
    fblq_pkg::cnt_t                       retired_reg, retired_next;
    fblq_pkg::time_t                      last_dep_reg, last_dep_next;
    logic [fblq_pkg::COUNT_W-1:0]         lost_reg, lost_next;
    logic [fblq_pkg::COUNT_W-1:0]         done_reg, done_next;
    logic [fblq_pkg::SUM_W-1:0]           dsum_reg, dsum_next;
    logic [fblq_pkg::LIMIT_W-1:0]         limit_reg;
    logic [fblq_pkg::BYTE_TIME_W-1:0]     byte_time_reg;

    logic                                 out_valid_reg, out_valid_next;
    logic                                 acc_out_reg;
    fblq_pkg::time_t                      dep_out_reg;
    fblq_pkg::time_t                      dly_out_reg;
    fblq_pkg::cnt_t                       retired_out_reg;
    fblq_pkg::cnt_t                       occ_out_reg;
    logic [fblq_pkg::COUNT_W-1:0]         lost_out_reg;
    logic [fblq_pkg::COUNT_W-1:0]         done_out_reg;
    logic [fblq_pkg::SUM_W-1:0]           dsum_out_reg;

    fblq_pkg::time_t                      head_dep;
    logic                                 in_fire;
    logic                                 pop;
    logic                                 out_free;
    logic                                 admit_done;
    logic [PROD_W-1:0]                    product;
    logic [PROD_W-1:0]                    rounded;
    int                                   eff_limit;
    logic                                 full;
    logic                                 late;
    fblq_pkg::time_t                      start_time;
    fblq_pkg::time_t                      delay;
    logic [fblq_pkg::TIME_BITS:0]         dep_sum;
    fblq_pkg::time_t                      dep;
    logic [fblq_pkg::SUM_W:0]             dsum_sum;
    logic [TS_W-1:0]                      tail_sum;
    logic [TS_W-1:0]                      tail_wrap;
    logic                                 mem_we;
    fblq_pkg::addr_t                      mem_waddr;
    fblq_pkg::addr_t                      head_inc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= fblq_pkg::LIMIT_RESET;
            byte_time_reg <= fblq_pkg::BYTE_TIME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == fblq_pkg::REG_BUFFER_LIMIT)
            begin
                limit_reg <= cfg_data[fblq_pkg::LIMIT_W-1:0];
            end
            else if (cfg_index == fblq_pkg::REG_BYTE_TIME)
            begin
                byte_time_reg <= cfg_data[fblq_pkg::BYTE_TIME_W-1:0];
            end
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign out_free   = !(out_valid_reg && out_stall);
    assign admit_done = (state_reg == ST_ADMIT) && out_free;
    assign pop        = (state_reg == ST_POP) && (held_reg != '0) && (head_dep < arr_reg);

    assign head_inc = (head_reg == fblq_pkg::ADDR_W'(fblq_pkg::QUEUE_DEPTH - 1))
                      ? '0 : head_reg + 1'b1;

    assign product = PROD_W'(size_reg) * PROD_W'(byte_time_reg);
    assign rounded = product + PROD_W'(128);

    assign eff_limit = (int'(limit_reg) > fblq_pkg::QUEUE_DEPTH)
                       ? fblq_pkg::QUEUE_DEPTH : int'(limit_reg);
    assign full      = int'(held_reg) >= eff_limit;

    assign late       = last_dep_reg > arr_reg;
    assign start_time = late ? last_dep_reg : arr_reg;
    assign delay      = late ? (last_dep_reg - arr_reg) : '0;
    assign dep_sum    = {1'b0, start_time} + (fblq_pkg::TIME_BITS + 1)'(service_reg);
    assign dep        = dep_sum[fblq_pkg::TIME_BITS] ? '1 : dep_sum[fblq_pkg::TIME_BITS-1:0];
    assign dsum_sum   = {1'b0, dsum_reg} + (fblq_pkg::SUM_W + 1)'(delay);

    assign tail_sum  = TS_W'(head_reg) + TS_W'(held_reg);
    assign tail_wrap = (tail_sum >= TS_W'(fblq_pkg::QUEUE_DEPTH))
                       ? tail_sum - TS_W'(fblq_pkg::QUEUE_DEPTH) : tail_sum;
    assign mem_waddr = tail_wrap[fblq_pkg::ADDR_W-1:0];
    assign mem_we    = admit_done && !full;

    always_comb
    begin
        state_next     = state_reg;
        arr_next       = arr_reg;
        size_next      = size_reg;
        head_next      = head_reg;
        held_next      = held_reg;
        retired_next   = retired_reg;
        last_dep_next  = last_dep_reg;
        lost_next      = lost_reg;
        done_next      = done_reg;
        dsum_next      = dsum_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    arr_next     = arrival_time;
                    size_next    = packet_size;
                    retired_next = '0;
                    state_next   = ST_POP;
                end
            end
            ST_POP:
            begin
                if (pop)
                begin
                    head_next    = head_inc;
                    held_next    = held_reg - 1'b1;
                    retired_next = retired_reg + 1'b1;
                    if (done_reg != '1)
                    begin
                        done_next = done_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_ADMIT;
                end
            end
            ST_ADMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (full)
                    begin
                        if (lost_reg != '1)
                        begin
                            lost_next = lost_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        held_next     = held_reg + 1'b1;
                        last_dep_next = dep;
                        dsum_next     = dsum_sum[fblq_pkg::SUM_W] ? '1
                                        : dsum_sum[fblq_pkg::SUM_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            held_reg      <= '0;
            last_dep_reg  <= '0;
            lost_reg      <= '0;
            done_reg      <= '0;
            dsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            held_reg      <= held_next;
            last_dep_reg  <= last_dep_next;
            lost_reg      <= lost_next;
            done_reg      <= done_next;
            dsum_reg      <= dsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arr_reg     <= arr_next;
        size_reg    <= size_next;
        retired_reg <= retired_next;
        if (state_reg == ST_POP)
        begin
            service_reg <= rounded[8 +: fblq_pkg::SERVICE_W];
        end
        if (admit_done)
        begin
            acc_out_reg     <= !full;
            dep_out_reg     <= full ? '0 : dep;
            dly_out_reg     <= full ? '0 : delay;
            retired_out_reg <= retired_reg;
            occ_out_reg     <= held_next;
            lost_out_reg    <= lost_next;
            done_out_reg    <= done_reg;
            dsum_out_reg    <= dsum_next;
        end
    end

    fblq_ram #(
        .WIDTH (fblq_pkg::TIME_BITS),
        .DEPTH (fblq_pkg::QUEUE_DEPTH)
    ) u_dep_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (dep),
        .raddr (head_next),
        .rdata (head_dep)
    );

    assign out_valid      = out_valid_reg;
    assign accepted       = acc_out_reg;
    assign departure_time = dep_out_reg;
    assign queue_delay    = dly_out_reg;
    assign retired_now    = fblq_pkg::FIELD7_W'(retired_out_reg);
    assign occupancy      = fblq_pkg::FIELD7_W'(occ_out_reg);
    assign lost_total     = lost_out_reg;
    assign done_total     = done_out_reg;
    assign delay_sum      = dsum_out_reg;

    a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(held_reg) <= fblq_pkg::QUEUE_DEPTH)
        else $error("Buffer occupancy exceeds its depth.");

    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (held_reg == $past(held_reg) - 1'b1) && (state_reg == ST_POP))
        else $error("A retirement did not reduce the occupancy by one.");

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (int'(held_reg) < eff_limit) && (state_reg == ST_ADMIT))
        else $error("A departure was written into a full buffer.");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        admit_done && full |=> out_valid_reg && !acc_out_reg
                               && (dep_out_reg == '0) && (dly_out_reg == '0))
        else $error("A dropped packet reported a departure or a delay.");

    a_admit_grows: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (held_reg == $past(held_reg) + 1'b1) && (occ_out_reg == held_reg))
        else $error("An admitted packet did not raise the occupancy by one.");

endmodule

// ===== bench/link_queue_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_queue_monitor
// Watches the packet, result and register channels of the link queue. Every
// packet word taken by the block is run through a local copy of the tail-drop
// buffer, and every result word taken from the block is checked field by
// field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module link_queue_monitor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [fblq_pkg::TIME_BITS-1:0]     arrival_time,
    input  logic [fblq_pkg::SIZE_W-1:0]        packet_size,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               accepted,
    input  logic [fblq_pkg::TIME_BITS-1:0]     departure_time,
    input  logic [fblq_pkg::TIME_BITS-1:0]     queue_delay,
    input  logic [fblq_pkg::FIELD7_W-1:0]      retired_now,
    input  logic [fblq_pkg::FIELD7_W-1:0]      occupancy,
    input  logic [fblq_pkg::COUNT_W-1:0]       lost_total,
    input  logic [fblq_pkg::COUNT_W-1:0]       done_total,
    input  logic [fblq_pkg::SUM_W-1:0]         delay_sum,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [fblq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fblq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                 fail_count,
    output int                                 outstanding,
    output int                                 packets_seen,
    output int                                 drops_seen,
    output int                                 retired_seen,
    output int                                 peak_held
);

    localparam logic [63:0] TIME_CEIL = (64'd1 << fblq_pkg::TIME_BITS) - 64'd1;

    typedef struct packed {
        logic                           accepted;
        fblq_pkg::time_t                departure;
        fblq_pkg::time_t                delay;
        logic [fblq_pkg::FIELD7_W-1:0]  retired;
        logic [fblq_pkg::FIELD7_W-1:0]  held;
        logic [fblq_pkg::COUNT_W-1:0]   lost;
        logic [fblq_pkg::COUNT_W-1:0]   done;
        logic [fblq_pkg::SUM_W-1:0]     delay_total;
    } link_outcome_t;

    fblq_pkg::time_t                  depart_ring [fblq_pkg::QUEUE_DEPTH];
    fblq_pkg::addr_t                  ring_head;
    fblq_pkg::cnt_t                   ring_count;
    fblq_pkg::time_t                  last_depart;
    logic [fblq_pkg::COUNT_W-1:0]     lost_count;
    logic [fblq_pkg::COUNT_W-1:0]     done_count;
    logic [fblq_pkg::SUM_W-1:0]       delay_total;
    logic [fblq_pkg::LIMIT_W-1:0]     limit_setting;
    logic [fblq_pkg::BYTE_TIME_W-1:0] byte_time_setting;

    link_outcome_t          outcomes_due [$];
    int                     mismatches;
    int                     packet_tally;
    int                     drop_tally;
    int                     retire_tally;
    int                     peak_tally;

    function automatic string field_label(input int idx);
        case (idx)
            0:       return "accepted";
            1:       return "departure_time";
            2:       return "queue_delay";
            3:       return "retired_now";
            4:       return "occupancy";
            5:       return "lost_total";
            6:       return "done_total";
            default: return "delay_sum";
        endcase
    endfunction

    // Departures strictly earlier than the arrival leave the head of the
    // buffer first; the packet is then dropped or appended behind the last one.
    task automatic predict_link_outcome(
        input  fblq_pkg::time_t               arrival,
        input  logic [fblq_pkg::SIZE_W-1:0]   pkt_len,
        output link_outcome_t                 res
    );
        logic [63:0]                   service;
        logic [63:0]                   start;
        logic [63:0]                   departure;
        logic [63:0]                   delay;
        logic [fblq_pkg::SUM_W:0]      sum;
        logic [fblq_pkg::FIELD7_W-1:0] retired;
        fblq_pkg::addr_t               slot;
        int                            cap;
        retired   = '0;
        departure = '0;
        delay     = '0;
        res       = '0;
        while (ring_count != 0 && depart_ring[ring_head] < arrival)
        begin
            ring_head  = ring_head + 1'b1;
            ring_count = ring_count - 1'b1;
            retired    = retired + 1'b1;
            if (done_count != '1)
                done_count = done_count + 1'b1;
        end
        cap = (int'(limit_setting) > fblq_pkg::QUEUE_DEPTH)
              ? fblq_pkg::QUEUE_DEPTH : int'(limit_setting);
        if (int'(ring_count) >= cap)
        begin
            if (lost_count != '1)
                lost_count = lost_count + 1'b1;
        end
        else
        begin
            service   = (64'(pkt_len) * 64'(byte_time_setting) + 64'd128) >> 8;
            start     = (last_depart > arrival) ? 64'(last_depart) : 64'(arrival);
            delay     = (last_depart > arrival) ? 64'(last_depart - arrival) : 64'd0;
            departure = start + service;
            if (departure > TIME_CEIL)
                departure = TIME_CEIL;
            slot = ring_head + ring_count[fblq_pkg::ADDR_W-1:0];
            depart_ring[slot] = departure[fblq_pkg::TIME_BITS-1:0];
            ring_count  = ring_count + 1'b1;
            last_depart = departure[fblq_pkg::TIME_BITS-1:0];
            sum = {1'b0, delay_total} + (fblq_pkg::SUM_W + 1)'(delay);
            delay_total = sum[fblq_pkg::SUM_W] ? '1 : sum[fblq_pkg::SUM_W-1:0];
            res.accepted = 1'b1;
        end
        res.departure   = departure[fblq_pkg::TIME_BITS-1:0];
        res.delay       = delay[fblq_pkg::TIME_BITS-1:0];
        res.retired     = retired;
        res.held        = ring_count;
        res.lost        = lost_count;
        res.done        = done_count;
        res.delay_total = delay_total;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        link_outcome_t fresh;
        link_outcome_t due;
        logic [63:0]   want [8];
        logic [63:0]   got [8];
        if (!rst_n)
        begin
            outcomes_due.delete();
            ring_head         = '0;
            ring_count        = '0;
            last_depart       = '0;
            lost_count        = '0;
            done_count        = '0;
            delay_total       = '0;
            limit_setting     = fblq_pkg::LIMIT_RESET;
            byte_time_setting = fblq_pkg::BYTE_TIME_RESET;
            mismatches        = 0;
            packet_tally      = 0;
            drop_tally        = 0;
            retire_tally      = 0;
            peak_tally        = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fblq_pkg::REG_BUFFER_LIMIT)
                    limit_setting = cfg_data[fblq_pkg::LIMIT_W-1:0];
                else if (cfg_index == fblq_pkg::REG_BYTE_TIME)
                    byte_time_setting = cfg_data[fblq_pkg::BYTE_TIME_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                predict_link_outcome(arrival_time, packet_size, fresh);
                outcomes_due.insert(outcomes_due.size(), fresh);
                packet_tally++;
                if (!fresh.accepted)
                    drop_tally++;
                retire_tally += int'(fresh.retired);
                if (int'(ring_count) > peak_tally)
                    peak_tally = int'(ring_count);
            end
            if (out_valid && !out_stall)
            begin
                if (outcomes_due.size() == 0)
                begin
                    mismatches++;
                    $error("result word taken with no packet outstanding");
                end
                else
                begin
                    due = outcomes_due.pop_front();
                    want[0] = 64'(due.accepted);     got[0] = 64'(accepted);
                    want[1] = 64'(due.departure);    got[1] = 64'(departure_time);
                    want[2] = 64'(due.delay);        got[2] = 64'(queue_delay);
                    want[3] = 64'(due.retired);      got[3] = 64'(retired_now);
                    want[4] = 64'(due.held);         got[4] = 64'(occupancy);
                    want[5] = 64'(due.lost);         got[5] = 64'(lost_total);
                    want[6] = 64'(due.done);         got[6] = 64'(done_total);
                    want[7] = 64'(due.delay_total);  got[7] = 64'(delay_sum);
                    for (int i = 0; i < 8; i++)
                    begin
                        if (want[i] !== got[i])
                        begin
                            mismatches++;
                            $error("%s: expected %0d, got %0d",
                                   field_label(i), want[i], got[i]);
                        end
                    end
                end
            end
        end
        fail_count   <= mismatches;
        outstanding  <= outcomes_due.size();
        packets_seen <= packet_tally;
        drops_seen   <= drop_tally;
        retired_seen <= retire_tally;
        peak_held    <= peak_tally;
    end

endmodule

// ===== bench/finite_buffer_link_queue_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// finite_buffer_link_queue_unit_test
// Drives packet words and register writes into the link queue. A short
// directed run covers zero sizes, equal times, backward arrivals and drop
// limits of zero, small and above the depth; random phases then sweep limits
// and per-byte times with bursts, jumps and out-of-order arrivals while both
// sides idle at random. A closing run saturates departures. The monitor checks.
// ----------------------------------------------------------------------------
module finite_buffer_link_queue_unit_test;

    localparam logic [fblq_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 8'hFF;
    localparam logic [63:0] TIME_CEIL      = (64'd1 << fblq_pkg::TIME_BITS) - 64'd1;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          LONG_HOLD      = 400;
    localparam int          PHASE_WORDS    = 290;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [fblq_pkg::TIME_BITS-1:0]   arrival_time;
    logic [fblq_pkg::SIZE_W-1:0]      packet_size;
    logic                             out_valid;
    logic                             out_stall;
    logic                             accepted;
    logic [fblq_pkg::TIME_BITS-1:0]   departure_time;
    logic [fblq_pkg::TIME_BITS-1:0]   queue_delay;
    logic [fblq_pkg::FIELD7_W-1:0]    retired_now;
    logic [fblq_pkg::FIELD7_W-1:0]    occupancy;
    logic [fblq_pkg::COUNT_W-1:0]     lost_total;
    logic [fblq_pkg::COUNT_W-1:0]     done_total;
    logic [fblq_pkg::SUM_W-1:0]       delay_sum;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [fblq_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fblq_pkg::CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int outstanding;
    int packets_seen;
    int drops_seen;
    int retired_seen;
    int peak_held;
    int quiet_cycles = 0;
    int calm_left = 0;
    int hold_requests = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    finite_buffer_link_queue_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .arrival_time   (arrival_time),
        .packet_size    (packet_size),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .departure_time (departure_time),
        .queue_delay    (queue_delay),
        .retired_now    (retired_now),
        .occupancy      (occupancy),
        .lost_total     (lost_total),
        .done_total     (done_total),
        .delay_sum      (delay_sum),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    link_queue_monitor monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .arrival_time   (arrival_time),
        .packet_size    (packet_size),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .departure_time (departure_time),
        .queue_delay    (queue_delay),
        .retired_now    (retired_now),
        .occupancy      (occupancy),
        .lost_total     (lost_total),
        .done_total     (done_total),
        .delay_sum      (delay_sum),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .packets_seen   (packets_seen),
        .drops_seen     (drops_seen),
        .retired_seen   (retired_seen),
        .peak_held      (peak_held)
    );

    function automatic logic [63:0] rand48();
        return {$urandom, $urandom} & TIME_CEIL;
    endfunction

    task automatic offer(input logic [63:0] arr,
                         input logic [fblq_pkg::SIZE_W-1:0] pkt_len);
        int gap;
        gap = 0;
        if (calm_left > 0)
            calm_left--;
        else
        begin
            case ($urandom_range(0, 15))
                0:          calm_left = $urandom_range(10, 40);
                1:          gap = $urandom_range(15, 60);
                2, 3, 4, 5: gap = $urandom_range(1, 4);
                default:    gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        arrival_time <= arr[fblq_pkg::TIME_BITS-1:0];
        packet_size  <= pkt_len;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [fblq_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fblq_pkg::CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receiver
        int run;
        int holds_taken;
        bit level;
        run         = 0;
        holds_taken = 0;
        level       = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_taken)
            begin
                holds_taken = hold_requests;
                level       = 1'b1;
                run         = LONG_HOLD;
            end
            else if (run <= 0)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        level = 1'b0;
                        run   = $urandom_range(50, 200);
                    end
                    1:
                    begin
                        level = 1'b1;
                        run   = $urandom_range(20, 60);
                    end
                    2, 3, 4:
                    begin
                        level = 1'b1;
                        run   = $urandom_range(1, 3);
                    end
                    default:
                    begin
                        level = 1'b0;
                        run   = $urandom_range(1, 4);
                    end
                endcase
            end
            out_stall <= level;
            run = run - 1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [63:0]                      now;
        logic [63:0]                      arr;
        logic [63:0]                      svc;
        logic [fblq_pkg::LIMIT_W-1:0]     lim;
        logic [fblq_pkg::BYTE_TIME_W-1:0] bt;
        logic [fblq_pkg::SIZE_W-1:0]      pkt_len;
        int                               burst;
        int                               words;
        bit                               noisy;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        arrival_time <= '0;
        packet_size  <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= fblq_pkg::REG_BUFFER_LIMIT;
        cfg_data     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(64'd0, 16'd0);
        offer(64'd0, 16'd0);
        offer(64'd1, 16'd1);
        offer(64'd1, 16'hFFFF);
        offer(64'd2, 16'd1500);
        offer(64'd1000, 16'd64);
        offer(64'd500, 16'd64);
        offer(64'd0, 16'd0);

        write_reg(REG_UNMAPPED, 24'hFFFFFF);
        write_reg(fblq_pkg::REG_BUFFER_LIMIT, 24'd0);
        offer(64'd100000000000, 16'd100);
        offer(64'd100000000000, 16'd100);

        write_reg(fblq_pkg::REG_BUFFER_LIMIT, 24'd2);
        write_reg(fblq_pkg::REG_BYTE_TIME, 24'd1);
        offer(64'd200000000000, 16'd127);
        offer(64'd200000000000, 16'd128);
        offer(64'd200000000000, 16'd384);
        offer(64'd200000000000, 16'hFFFF);

        // A limit word of all ones asks for more than the buffer can hold.
        write_reg(fblq_pkg::REG_BUFFER_LIMIT, 24'hFFFFFF);
        write_reg(fblq_pkg::REG_BYTE_TIME, 24'hFFFFFF);
        offer(64'd300000000000, 16'hFFFF);
        offer(64'd300000000000, 16'hFFFF);
        offer(64'd300000000000, 16'hFFFF);
        offer(64'd300000000001, 16'd0);

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    lim = 7'd64;
                    bt  = fblq_pkg::BYTE_TIME_RESET;
                end
                1:
                begin
                    lim = 7'd127;
                    bt  = 24'hFFFFFF;
                end
                2:
                begin
                    lim = 7'd1;
                    bt  = 24'd256;
                end
                3:
                begin
                    lim = 7'd8;
                    bt  = 24'd1;
                end
                4:
                begin
                    lim = fblq_pkg::LIMIT_W'($urandom_range(2, 63));
                    bt  = fblq_pkg::BYTE_TIME_W'($urandom_range(1, 24'hFFFFFF));
                end
                5:
                begin
                    lim = 7'd0;
                    bt  = fblq_pkg::BYTE_TIME_W'($urandom_range(1, 24'hFFFFFF));
                end
                default:
                begin
                    lim = fblq_pkg::LIMIT_RESET;
                    bt  = fblq_pkg::BYTE_TIME_RESET;
                end
            endcase
            words = (lim == 0) ? 40 : PHASE_WORDS;
            write_reg(fblq_pkg::REG_BUFFER_LIMIT, {17'd0, lim});
            write_reg(fblq_pkg::REG_BYTE_TIME, bt);
            now   = (64'(p + 1) << 45) + (rand48() & ((64'd1 << 44) - 64'd1));
            svc   = ((64'd1000 * 64'(bt)) >> 8) + 64'd1;
            burst = 0;
            for (int k = 0; k < words; k++)
            begin
                if (k == 20 && (p == 0 || p == 4))
                    hold_requests++;
                noisy = 1'b0;
                if (burst > 0)
                    burst--;
                else
                begin
                    case ($urandom_range(0, 19))
                        0:       noisy = 1'b1;
                        1:       now = now + svc * 64'($urandom_range(50, 200));
                        2:       burst = $urandom_range(5, 70);
                        default: now = now + 64'($urandom_range(0, 32'(6 * svc)));
                    endcase
                end
                arr = noisy ? now - (rand48() % (now + 64'd1)) : now;
                case ($urandom_range(0, 31))
                    0, 1:    pkt_len = 16'd0;
                    2:       pkt_len = 16'hFFFF;
                    3, 4:    pkt_len = fblq_pkg::SIZE_W'($urandom_range(0, 65535));
                    default: pkt_len = fblq_pkg::SIZE_W'($urandom_range(40, 1500));
                endcase
                offer(arr, pkt_len);
            end
        end

        // Departures pinned at the top of the time range never retire.
        write_reg(fblq_pkg::REG_BUFFER_LIMIT, 24'd3);
        write_reg(fblq_pkg::REG_BYTE_TIME, 24'hFFFFFF);
        offer(TIME_CEIL - 64'd1000, 16'hFFFF);
        offer(TIME_CEIL, 16'd0);
        offer(TIME_CEIL, 16'hFFFF);
        offer(TIME_CEIL, 16'd1);

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (20) @(posedge clk);
        $display("Run covered %0d packets: %0d dropped, %0d retired, peak occupancy %0d.",
                 packets_seen, drops_seen, retired_seen, peak_held);
        $display("Limits 0 to 127 and per-byte times 1 to full scale, with long receiver holds.");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
